// ===== rtl/assert_macros.svh =====
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define CVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/cvt_pkg.sv =====
// types, constants and op codes shared by the constant verification table
`default_nettype none
package cvt_pkg;

  localparam int ENTRIES    = 8;
  localparam int INDEX_BITS = 10;

  localparam int ADDR_W   = 64;
  localparam int PIDX_W   = 10;
  localparam int RCNT_W   = 4;
  localparam int OP_W     = 3;
  // stored index width: the request field already limits it to ten bits
  localparam int SIDX_W   = (INDEX_BITS < PIDX_W) ? INDEX_BITS : PIDX_W;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int PTR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [OP_W-1:0] OP_INSERT       = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE_ADDR  = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_INDEX = 3'd2;
  localparam logic [OP_W-1:0] OP_CHECK_STORE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK_LOAD   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR        = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [PIDX_W-1:0] pred_index;
  } in_req_t;

  typedef struct packed {
    logic              hit;
    logic [RCNT_W-1:0] removed_count;
  } out_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_remove;
    logic scan_done;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/constant_verification_table.sv =====
// Constant verification table: an insertion-ordered table of ENTRIES
// (address, predictor index) pairs. Insert, store check, load check, clear
// and unused op codes need no sweep: the result is registered at the
// edge that accepts the request, and the next request can be taken in the
// following cycle. A remove by address or by index compacts the table with
// a read/write pointer pair that visits one stored entry per cycle, so it
// holds the block until its count is registered. A new request is taken
// only while the result register is empty or being emptied in that cycle.
`default_nettype none
module constant_verification_table (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  cvt_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  wire               out_ready,
  output cvt_pkg::out_rsp_t out_rsp
);
  import cvt_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  cvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cvt_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .status  (status),
    .out_rsp (out_rsp)
  );

endmodule
`default_nettype wire

// ===== rtl/cvt_ctrl.sv =====
// controller: request handshake, remove sweep sequencing, result valid
`default_nettype none
module cvt_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  cvt_pkg::dp_status_t status,
  output cvt_pkg::ctl_cmd_t   cmd
);
  import cvt_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_PURGE = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.start  = in_valid && in_ready;
    cmd.step   = (state_r == S_PURGE) && !status.scan_done;
    cmd.finish = (state_r == S_PURGE) && status.scan_done && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.start && status.is_remove) state_nxt = S_PURGE;
      end
      S_PURGE: begin
        if (cmd.finish) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((cmd.start && !status.is_remove) || cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cvt_dp.sv =====
// datapath: entry registers, parallel compare, compaction sweep, result register
`default_nettype none
module cvt_dp (
  input  wire                 clk,
  input  wire                 rst_n,
  input  cvt_pkg::in_req_t    in_req,
  input  cvt_pkg::ctl_cmd_t   cmd,
  output cvt_pkg::dp_status_t status,
  output cvt_pkg::out_rsp_t   out_rsp
);
  import cvt_pkg::*;

  logic [ADDR_W-1:0] entry_addr_r [ENTRIES];
  logic [SIDX_W-1:0] entry_idx_r  [ENTRIES];
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  rd_r;
  logic [CNT_W-1:0]  wr_r;
  logic [CNT_W-1:0]  gone_r;
  logic              by_index_r;
  logic [ADDR_W-1:0] key_addr_r;
  logic [SIDX_W-1:0] key_idx_r;
  out_rsp_t          out_r;

  logic [SIDX_W-1:0]   req_idx;
  logic [ENTRIES-1:0]  addr_match;
  logic [ENTRIES-1:0]  load_match;
  logic                full;
  logic                probe_hit;
  logic [ADDR_W-1:0]   rd_addr;
  logic [SIDX_W-1:0]   rd_idx;
  logic [CNT_W+RCNT_W-1:0] gone_ext;
  out_rsp_t            now_rsp;

  assign req_idx = in_req.pred_index[SIDX_W-1:0];
  assign full    = (count_r == CNT_W'(ENTRIES));

  // all live entries compared at once for the checks
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      addr_match[i] = (CNT_W'(i) < count_r) && (entry_addr_r[i] == in_req.address);
      load_match[i] = addr_match[i] && (entry_idx_r[i] == req_idx);
    end
  end

  assign status.is_remove = (in_req.operation == OP_REMOVE_ADDR) ||
                            (in_req.operation == OP_REMOVE_INDEX);
  assign status.scan_done = (rd_r >= count_r);

  assign rd_addr   = entry_addr_r[rd_r[PTR_W-1:0]];
  assign rd_idx    = entry_idx_r[rd_r[PTR_W-1:0]];
  assign probe_hit = by_index_r ? (rd_idx == key_idx_r) : (rd_addr == key_addr_r);
  assign gone_ext  = {{RCNT_W{1'b0}}, gone_r};

  always_comb begin
    now_rsp.hit           = 1'b0;
    now_rsp.removed_count = '0;
    unique case (in_req.operation)
      OP_CHECK_STORE: now_rsp.hit = |addr_match;
      OP_CHECK_LOAD:  now_rsp.hit = |load_match;
      default:        now_rsp.hit = 1'b0;
    endcase
  end

  // entry storage: append with drop-oldest, and the compaction write
  always_ff @(posedge clk) begin
    if (cmd.start && (in_req.operation == OP_INSERT)) begin
      if (full) begin
        for (int i = 0; i < ENTRIES - 1; i++) begin
          entry_addr_r[i] <= entry_addr_r[i+1];
          entry_idx_r[i]  <= entry_idx_r[i+1];
        end
        entry_addr_r[ENTRIES-1] <= in_req.address;
        entry_idx_r[ENTRIES-1]  <= req_idx;
      end else begin
        entry_addr_r[count_r[PTR_W-1:0]] <= in_req.address;
        entry_idx_r[count_r[PTR_W-1:0]]  <= req_idx;
      end
    end else if (cmd.step && !probe_hit) begin
      entry_addr_r[wr_r[PTR_W-1:0]] <= rd_addr;
      entry_idx_r[wr_r[PTR_W-1:0]]  <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rd_r    <= '0;
      wr_r    <= '0;
      gone_r  <= '0;
    end else begin
      if (cmd.start) begin
        rd_r   <= '0;
        wr_r   <= '0;
        gone_r <= '0;
        unique case (in_req.operation)
          OP_INSERT: if (!full) count_r <= count_r + CNT_W'(1);
          OP_CLEAR:  count_r <= '0;
          default:   count_r <= count_r;
        endcase
      end
      if (cmd.step) begin
        rd_r <= rd_r + CNT_W'(1);
        if (probe_hit) begin
          gone_r <= gone_r + CNT_W'(1);
        end else begin
          wr_r <= wr_r + CNT_W'(1);
        end
      end
      if (cmd.finish) count_r <= wr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      by_index_r <= (in_req.operation == OP_REMOVE_INDEX);
      key_addr_r <= in_req.address;
      key_idx_r  <= req_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && !status.is_remove) begin
      out_r <= now_rsp;
    end else if (cmd.finish) begin
      out_r.hit           <= 1'b0;
      out_r.removed_count <= gone_ext[RCNT_W-1:0];
    end
  end

  assign out_rsp = out_r;

endmodule
`default_nettype wire

// ===== rtl/cvt_checker.sv =====
// port-level checker for the constant verification table, with its bind
`default_nettype none
`include "assert_macros.svh"
module cvt_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_ready,
  input cvt_pkg::in_req_t  in_req,
  input wire               out_valid,
  input wire               out_ready,
  input cvt_pkg::out_rsp_t out_rsp
);
  import cvt_pkg::*;

  // a stalled result keeps its valid
  `CVT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // a check request gives its result in the next cycle
  `CVT_ASSERT_NXT(a_check_lat, clk, rst_n,
    in_valid && in_ready && (in_req.operation == OP_CHECK_STORE ||
    in_req.operation == OP_CHECK_LOAD), out_valid)

  // only removes report a count, and only checks report a hit
  `CVT_ASSERT_IMP(a_hit_no_cnt, clk, rst_n, out_valid && out_rsp.hit,
    out_rsp.removed_count == '0)

  // a remove never deletes more than the table holds
  `CVT_ASSERT_IMP(a_cnt_bound, clk, rst_n, out_valid && (ENTRIES < 16),
    out_rsp.removed_count <= RCNT_W'(ENTRIES))

endmodule

bind constant_verification_table cvt_checker u_cvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp)
);
`default_nettype wire

// ===== test/tb_constant_verification_table.sv =====
// self-checking testbench for the constant verification table: directed rows, then random requests
`default_nettype none
module tb_constant_verification_table;
  import cvt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam int NUM_RANDOM  = 1000;
  localparam int QUIET_TAIL  = 150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 6;
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_rsp_t rsp;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_rsp;

  // shadow copy of the table
  logic [ADDR_W-1:0] tbl_addr [ENTRIES];
  logic [SIDX_W-1:0] tbl_idx  [ENTRIES];
  int                tbl_fill;

  out_rsp_t  rsp_expected [$];
  stim_row_t stim_table [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        idle_odds = 0;
  int        stall_left = 0;
  int        pool_span;
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  logic [PIDX_W-1:0] idx_pool  [POOL_SIZE];

  constant_verification_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // applies one request to the shadow table and returns the answer it gives
  function automatic out_rsp_t table_apply(in_req_t req);
    out_rsp_t          rsp;
    logic [SIDX_W-1:0] idx;
    int                wr;
    int                gone;
    logic              match;
    rsp  = '0;
    idx  = req.pred_index[SIDX_W-1:0];
    wr   = 0;
    gone = 0;
    case (req.operation)
      OP_INSERT: begin
        if (tbl_fill >= ENTRIES) begin
          for (int i = 1; i < ENTRIES; i++) begin
            tbl_addr[i-1] = tbl_addr[i];
            tbl_idx[i-1]  = tbl_idx[i];
          end
          tbl_fill = ENTRIES - 1;
        end
        tbl_addr[tbl_fill] = req.address;
        tbl_idx[tbl_fill]  = idx;
        tbl_fill++;
      end
      OP_REMOVE_ADDR, OP_REMOVE_INDEX: begin
        for (int rd = 0; rd < tbl_fill; rd++) begin
          match = (req.operation == OP_REMOVE_ADDR) ? (tbl_addr[rd] == req.address)
                                                    : (tbl_idx[rd] == idx);
          if (match) begin
            gone++;
          end else begin
            tbl_addr[wr] = tbl_addr[rd];
            tbl_idx[wr]  = tbl_idx[rd];
            wr++;
          end
        end
        tbl_fill = wr;
        rsp.removed_count = gone[RCNT_W-1:0];
      end
      OP_CHECK_STORE: begin
        for (int i = 0; i < tbl_fill; i++)
          if (tbl_addr[i] == req.address) rsp.hit = 1'b1;
      end
      OP_CHECK_LOAD: begin
        for (int i = 0; i < tbl_fill; i++)
          if (tbl_addr[i] == req.address && tbl_idx[i] == idx) rsp.hit = 1'b1;
      end
      OP_CLEAR: begin
        tbl_fill = 0;
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  task automatic add_row(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                         logic [PIDX_W-1:0] idx, bit typed, logic hit,
                         logic [RCNT_W-1:0] cnt);
    stim_row_t row;
    row.req.operation      = op;
    row.req.address        = addr;
    row.req.pred_index     = idx;
    row.typed              = typed;
    row.rsp.hit            = hit;
    row.rsp.removed_count  = cnt;
    stim_table = {stim_table, row};
  endtask

  // drives one request, waits for the handshake and records what must come back
  task automatic send_request(in_req_t req, bit typed, out_rsp_t typed_rsp);
    out_rsp_t predicted;
    if (idle_odds != 0 && $urandom_range(0, 9) < idle_odds) begin
      repeat ($urandom_range(1, 3)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = table_apply(req);
    if (typed) predicted = typed_rsp;
    rsp_expected = {rsp_expected, predicted};
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rsp_expected.size() != 0) @(negedge clk);
  endtask

  function automatic in_req_t random_request();
    in_req_t req;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      req.operation = OP_INSERT;
    else if (pick < 55) req.operation = OP_CHECK_STORE;
    else if (pick < 72) req.operation = OP_CHECK_LOAD;
    else if (pick < 82) req.operation = OP_REMOVE_ADDR;
    else if (pick < 90) req.operation = OP_REMOVE_INDEX;
    else if (pick < 93) req.operation = OP_CLEAR;
    else                req.operation = OP_W'($urandom_range(OP_INSERT, OP_UNUSED_HI));
    if ($urandom_range(0, 99) < 85) req.address = addr_pool[$urandom_range(0, pool_span)];
    else                            req.address = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 80) req.pred_index = idx_pool[$urandom_range(0, pool_span)];
    else                            req.pred_index = PIDX_W'($urandom);
    return req;
  endfunction

  // receiver side: stalls come in short bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_odds != 0 && $urandom_range(0, 9) < idle_odds) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rsp_expected.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected response: hit=%0b removed=%0d", out_rsp.hit,
                   out_rsp.removed_count);
        mismatch_count++;
      end else begin
        want = rsp_expected.pop_front();
        if (out_rsp.hit !== want.hit || out_rsp.removed_count !== want.removed_count) begin
          if (mismatch_count < 10)
            $display("mismatch at cycle %0d: expected hit=%0b removed=%0d, got hit=%0b removed=%0d",
                     cycle_count, want.hit, want.removed_count, out_rsp.hit,
                     out_rsp.removed_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    out_rsp_t blank;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;
    blank    = '0;
    tbl_fill = 0;
    addr_pool[0] = '0;
    addr_pool[1] = ADDR_ONES;
    idx_pool[0]  = '0;
    idx_pool[1]  = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      addr_pool[i] = {$urandom, $urandom};
      idx_pool[i]  = PIDX_W'($urandom);
    end

    // empty table, extremes, unused codes
    add_row(OP_CHECK_STORE,  '0,        '0,     1, 1'b0, '0);
    add_row(OP_CHECK_LOAD,   ADDR_ONES, '1,     1, 1'b0, '0);
    add_row(OP_REMOVE_ADDR,  ADDR_ONES, '0,     1, 1'b0, '0);
    add_row(OP_REMOVE_INDEX, '0,        '1,     1, 1'b0, '0);
    add_row(OP_UNUSED_LO,    ADDR_ONES, '1,     1, 1'b0, '0);
    add_row(OP_UNUSED_HI,    '0,        '0,     1, 1'b0, '0);
    add_row(OP_INSERT,       '0,        '0,     1, 1'b0, '0);
    add_row(OP_INSERT,       ADDR_ONES, '1,     1, 1'b0, '0);
    add_row(OP_CHECK_STORE,  ADDR_ONES, '0,     1, 1'b1, '0);
    add_row(OP_CHECK_LOAD,   ADDR_ONES, '1,     1, 1'b1, '0);
    add_row(OP_CHECK_LOAD,   ADDR_ONES, '0,     0, 1'b0, '0);
    // fill past capacity so the oldest entry drops out
    add_row(OP_INSERT, 64'h5555_5555_5555_5555, 10'h155, 0, 1'b0, '0);
    add_row(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 10'h2AA, 0, 1'b0, '0);
    add_row(OP_INSERT, 64'h5555_5555_5555_5555, 10'h2AA, 0, 1'b0, '0);
    add_row(OP_INSERT, 64'h1,                   '1,      0, 1'b0, '0);
    add_row(OP_INSERT, 64'h1,                   10'h5,   0, 1'b0, '0);
    add_row(OP_INSERT, 64'h8000_0000_0000_0000, 10'h200, 0, 1'b0, '0);
    add_row(OP_INSERT, 64'h2,                   10'h3,   0, 1'b0, '0);
    add_row(OP_CHECK_STORE,  '0,                    '0, 0, 1'b0, '0);
    // removes with and without a match
    add_row(OP_REMOVE_ADDR,  '0,                    '0, 0, 1'b0, '0);
    add_row(OP_REMOVE_ADDR,  64'h5555_5555_5555_5555, '0, 0, 1'b0, '0);
    add_row(OP_REMOVE_INDEX, '0,                    '1, 0, 1'b0, '0);
    add_row(OP_CHECK_LOAD,   64'h1,                 10'h5, 0, 1'b0, '0);
    add_row(OP_CLEAR,        ADDR_ONES,             '1, 1, 1'b0, '0);
    add_row(OP_CHECK_STORE,  64'h2,                 '0, 1, 1'b0, '0);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i])
      send_request(stim_table[i].req, stim_table[i].typed, stim_table[i].rsp);
    wait_for_drain();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 100 == 0) begin
        pool_span = $urandom_range(0, POOL_SIZE - 1);
        idle_odds = (n >= NUM_RANDOM - QUIET_TAIL) ? 0 : $urandom_range(0, 4);
      end
      if (n == NUM_RANDOM / 2) wait_for_drain();
      send_request(random_request(), 1'b0, blank);
    end
    idle_odds = 0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (rsp_expected.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);

    if (mismatch_count == 0 && rsp_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== constant_verification_table.f =====
+incdir+rtl
rtl/cvt_pkg.sv
rtl/cvt_ctrl.sv
rtl/cvt_dp.sv
rtl/constant_verification_table.sv
rtl/cvt_checker.sv
test/tb_constant_verification_table.sv
